>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge once reset is released.
`define RKS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that a condition never holds once reset is released.
`define RKS_NEVER(label, clk, rst_n, cond, msg) \
    `RKS_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> hw/rtl/rks_pkg.sv
// Package with widths, types, states and helpers of the running K-smallest sum block.
package rks_pkg;

    localparam int MAX_KEEP  = 1024;
    localparam int VALUE_W   = 20;
    localparam int KEEP_W    = 11;
    localparam int SUM_OUT_W = 30;
    localparam int ADDR_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int SIZE_W    = $clog2(MAX_KEEP + 1);
    localparam int SUM_IN_W  = VALUE_W + ((MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 0);
    localparam int SUM_W     = (SUM_IN_W > SUM_OUT_W) ? SUM_IN_W : SUM_OUT_W;

    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [KEEP_W-1:0]    t_keep;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [SIZE_W-1:0]    t_size;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [SUM_OUT_W-1:0] t_sum_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

    // Clamp the programmed K to 1..MAX_KEEP.
    function automatic t_size eff_k(input t_keep keep);
        logic [31:0] kk;
        kk = 32'(keep);
        if (kk == 32'd0) begin
            return t_size'(1);
        end else if (kk > 32'(MAX_KEEP)) begin
            return t_size'(MAX_KEEP);
        end else begin
            return t_size'(kk);
        end
    endfunction

endpackage

>>> hw/rtl/rks_in_if.sv
// Input channel: restart flag and value with valid/ready.
interface rks_in_if import rks_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   restart;
    t_value value;

    modport source (output valid, output restart, output value, input ready);
    modport sink   (input valid, input restart, input value, output ready);
endinterface

>>> hw/rtl/rks_out_if.sv
// Output channel: running sum and full flag with valid/ready.
interface rks_out_if import rks_pkg::*; ();
    logic     valid;
    logic     ready;
    t_sum_out running_sum;
    logic     full_res;

    modport source (output valid, output running_sum, output full_res, input ready);
    modport sink   (input valid, input running_sum, input full_res, output ready);
endinterface

>>> hw/rtl/running_k_smallest_sum.sv
// Running sum of the K smallest values, kept in a max-heap held in on-chip RAM.
//
// One item is worked at a time; ready is high whenever the heap sequencer is idle,
// even while the previous result beat still waits in the output register. A value
// that is dropped goes straight to the finish step. A value that grows the heap
// climbs one level at a time (read parent, compare and write), a value that replaces
// the maximum sinks one level at a time (read both children on the two read ports,
// compare and write).
// The heap RAM needs no clearing after reset; the fill count guards every read used.
`include "assert_macros.svh"

module running_k_smallest_sum import rks_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rks_in_if.sink     i_in,
    rks_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  t_keep      i_cfg_data
);

    localparam int CW = ADDR_W + 2;

    // heap RAM: one write port, two registered read ports
    t_value mem [MAX_KEEP];
    t_value r_rd_a, r_rd_b;
    t_value r_root;

    t_state   r_state, n_state;
    t_addr    r_pos, n_pos;
    t_value   r_val, n_val;
    t_size    r_size, n_size;
    t_sum     r_sum, n_sum;
    logic     r_rv, n_rv;
    t_keep    r_keep;
    logic     r_out_valid, n_out_valid;
    t_sum_out r_out_sum, n_out_sum;
    logic     r_out_full, n_out_full;

    logic     mem_we;
    t_addr    waddr, raddr_a, raddr_b;
    t_value   wdata;
    logic     rd_en;

    logic     in_acc;
    t_size    k_eff, size0;
    t_sum     sum0;
    t_addr    parent;
    logic [CW-1:0] left_w, right_w, size_w;
    logic     take_left, take_right;
    t_value   cand;

    assign k_eff   = eff_k(r_keep);
    assign in_acc  = i_in.valid && (r_state == S_IDLE);
    assign parent  = t_addr'((r_pos - t_addr'(1)) >> 1);
    assign left_w  = CW'({r_pos, 1'b1});
    assign right_w = left_w + CW'(1);
    assign size_w  = CW'(r_size);
    assign size0   = i_in.restart ? '0 : r_size;
    assign sum0    = i_in.restart ? '0 : r_sum;

    // pick the larger child that beats the sinking value
    assign take_left  = r_rd_a > r_val;
    assign cand       = take_left ? r_rd_a : r_val;
    assign take_right = r_rv && (r_rd_b > cand);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.running_sum = r_out_sum;
    assign o_out.full_res    = r_out_full;

    // hold the programmed K
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= t_keep'(1);
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_data;
        end
    end

    // heap RAM access and root mirror
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
            if (waddr == '0) begin
                r_root <= wdata;
            end
        end
        if (rd_en) begin
            r_rd_a <= mem[raddr_a];
            r_rd_b <= mem[raddr_b];
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers of the sift
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_rv       <= n_rv;
        r_out_sum  <= n_out_sum;
        r_out_full <= n_out_full;
    end

    // sequencer: insert with sift-up, replace root with sift-down
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_val       = r_val;
        n_size      = r_size;
        n_sum       = r_sum;
        n_rv        = r_rv;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_full  = r_out_full;
        mem_we      = 1'b0;
        waddr       = r_pos;
        wdata       = r_val;
        rd_en       = 1'b0;
        raddr_a     = parent;
        raddr_b     = right_w[ADDR_W-1:0];

        // drop the result beat once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val = i_in.value;
                    n_pos = '0;
                    if (size0 < k_eff) begin
                        n_size  = size0 + t_size'(1);
                        n_sum   = sum0 + SUM_W'(i_in.value);
                        n_pos   = size0[ADDR_W-1:0];
                        n_state = S_UP_RD;
                    end else if ((size0 != '0) && (i_in.value < r_root)) begin
                        n_size  = size0;
                        n_sum   = sum0 - SUM_W'(r_root) + SUM_W'(i_in.value);
                        n_state = S_DN_RD;
                    end else begin
                        n_size  = size0;
                        n_sum   = sum0;
                        n_state = S_DONE;
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_rd_a >= r_val) begin
                    n_state = S_DONE;
                end else begin
                    wdata   = r_rd_a;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end
            end
            S_DN_RD: begin
                if (left_w >= size_w) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    raddr_a = left_w[ADDR_W-1:0];
                    n_rv    = right_w < size_w;
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (take_right) begin
                    wdata   = r_rd_b;
                    n_pos   = right_w[ADDR_W-1:0];
                    n_state = S_DN_RD;
                end else if (take_left) begin
                    wdata   = r_rd_a;
                    n_pos   = left_w[ADDR_W-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = (r_sum > SUM_W'(2 ** SUM_OUT_W - 1)) ?
                                  {SUM_OUT_W{1'b1}} : r_sum[SUM_OUT_W-1:0];
                    n_out_full  = r_size >= k_eff;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `RKS_ASSERT(a_size_bound, i_clk, i_rst_n, r_size <= t_size'(MAX_KEEP),
        "heap fill count beyond capacity")
    `RKS_ASSERT(a_we_in_sift, i_clk, i_rst_n,
        mem_we |-> (r_state == S_UP_RD || r_state == S_UP_CMP ||
                    r_state == S_DN_RD || r_state == S_DN_CMP),
        "heap write outside a sift")
    `RKS_ASSERT(a_dn_pos, i_clk, i_rst_n,
        (r_state == S_DN_CMP) |-> (CW'(r_pos) < size_w),
        "sift-down position beyond heap fill")
    `RKS_ASSERT(a_beat_from_done, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_DONE),
        "result beat raised outside the finish step")

endmodule
